>>> src/isbc_pkg.sv
// Shared widths, codes and the gyroscope gain table for the IMU scale/bias block.
// Depends on nothing; the top level and the port checker import it.
package isbc_pkg;

	localparam int RAW_W      = 16;
	localparam int ACC_W      = 22;
	localparam int GYR_W      = 29;
	localparam int ASUM_W     = 38;
	localparam int GSUM_W     = 45;
	localparam int CNT_W      = 16;
	localparam int K_W        = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int S_DATA_W   = 96;
	localparam int M_DATA_W   = 160;
	localparam int MUL_STEPS  = RAW_W;
	localparam int DIV_STEPS  = GSUM_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RANGE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_RANGE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CALIB_MODE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CALIB_SAMPLES = 2'd3;

	// calibration modes; the remaining code converts as normal
	localparam logic [1:0] MODE_NORMAL    = 2'd0;
	localparam logic [1:0] MODE_GYRO_CAL  = 2'd1;
	localparam logic [1:0] MODE_ACCEL_CAL = 2'd2;

	localparam logic [CFG_DATA_W-1:0] CALIB_SAMPLES_RST = 16'd100;

	// round(2^24 / sensitivity) for 250, 500, 1000 and 2000 dps
	localparam logic [K_W-1:0] GYRO_K [4] = '{20'd128070, 20'd256141, 20'd511500, 20'd1023001};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIN,
		ST_DIV,
		ST_BIAS
	} state_t;

	typedef struct packed {
		logic s_ready;
		logic mul_en;
		logic fin_go;
		logic div_en;
		logic bias_en;
	} ctrl_t;

endpackage

>>> src/imu_scale_bias_calibrate.sv
// IMU raw-to-units conversion with bias removal and bias calibration (top level).
// Bit-serial gyroscope multiplier lanes and a bit-serial restoring divider.
// Depends on isbc_pkg.
//
// Sequence: an accepted item runs 16 multiplier steps in the bit-serial gyroscope
//   lanes, then a finishing step that loads the output register once it has room.
// The input takes no new item until the last one is through; an item that completes
//   a calibration window adds 45 restoring division steps and one bias write first.
// Reset: arst_n clears state asynchronously; registers take their reset values,
//   biases, sums and the sample count go to zero, calib_samples to 100.
module imu_scale_bias_calibrate #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [isbc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [isbc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// raw_ax, raw_ay, raw_az, raw_gx, raw_gy, raw_gz (16 bits each)
	input  logic [isbc_pkg::S_DATA_W-1:0]       s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// accel_x_g, accel_y_g, accel_z_g (22 bits each),
	// rate_x_dps, rate_y_dps, rate_z_dps (29 bits each), 7 zero bits
	output logic [isbc_pkg::M_DATA_W-1:0]       m_tdata,
	// calib_done
	output logic [0:0]                          m_tuser
);
	import isbc_pkg::*;

	// accelerometer shift before range, gyroscope shift after the multiply
	localparam int ASH    = FRAC_BITS - 14;
	localparam int GSH    = 24 - FRAC_BITS;
	localparam int HI_W   = K_W + 2;
	localparam int PROD_W = HI_W + RAW_W;
	localparam int WIDE_W = 48;
	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam int PAD_W  = M_DATA_W - 3 * ACC_W - 3 * GYR_W;

	localparam logic signed [WIDE_W-1:0] A_HI = WIDE_W'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
	localparam logic signed [WIDE_W-1:0] A_LO = -A_HI - WIDE_W'(1);
	localparam logic signed [WIDE_W-1:0] G_HI = WIDE_W'((64'sd1 <<< (GYR_W - 1)) - 64'sd1);
	localparam logic signed [WIDE_W-1:0] G_LO = -G_HI - WIDE_W'(1);
	// one g on the Z axis
	localparam logic signed [WIDE_W-1:0] ONE_G = WIDE_W'(64'sd1 <<< FRAC_BITS);

	function automatic logic signed [ACC_W-1:0] sat_a(input logic signed [WIDE_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		if (v > A_HI) begin
			r = A_HI[ACC_W-1:0];
		end else if (v < A_LO) begin
			r = A_LO[ACC_W-1:0];
		end else begin
			r = v[ACC_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [GYR_W-1:0] sat_g(input logic signed [WIDE_W-1:0] v);
		logic signed [GYR_W-1:0] r;
		if (v > G_HI) begin
			r = G_HI[GYR_W-1:0];
		end else if (v < G_LO) begin
			r = G_LO[GYR_W-1:0];
		end else begin
			r = v[GYR_W-1:0];
		end
		return r;
	endfunction

	// configuration
	logic [1:0]            accel_range_q;
	logic [1:0]            gyro_range_q;
	logic [1:0]            calib_mode_q;
	logic [CNT_W-1:0]      calib_samples_q;

	// sequencer
	state_t                state_q, state_d;
	ctrl_t                 ctrl;
	logic [STEP_W-1:0]     step_q;
	logic                  mul_last;
	logic                  div_last;

	// item hold and multiplier lanes
	logic signed [RAW_W-1:0] raw_a_q [3];
	logic signed [HI_W-1:0]  mhi_q   [3];
	logic [RAW_W-1:0]        mlo_q   [3];
	logic [K_W-1:0]          kval_q;
	logic signed [HI_W-1:0]  msum    [3];

	// calibration state
	logic signed [ACC_W-1:0]  abias_q [3];
	logic signed [GYR_W-1:0]  gbias_q [3];
	logic signed [ASUM_W-1:0] asum_q  [3];
	logic signed [GSUM_W-1:0] gsum_q  [3];
	logic [CNT_W-1:0]         cnt_q;

	// finishing cycle
	logic signed [ACC_W-1:0]  a_val   [3];
	logic signed [GYR_W-1:0]  g_val   [3];
	logic signed [ACC_W-1:0]  a_out   [3];
	logic signed [GYR_W-1:0]  g_out   [3];
	logic signed [ASUM_W-1:0] asum_n  [3];
	logic signed [GSUM_W-1:0] gsum_n  [3];
	logic signed [GSUM_W-1:0] div_src [3];
	logic [CNT_W-1:0]         cnt_n;
	logic [CNT_W-1:0]         win_n;
	logic                     cal_on;
	logic                     done;
	logic                     cfg_clear;

	// divider lanes
	logic [GSUM_W-1:0]        dq_q    [3];
	logic [CNT_W-1:0]         drem_q  [3];
	logic                     dneg_q  [3];
	logic [CNT_W-1:0]         ddiv_q;
	logic                     dacc_q;
	logic [CNT_W:0]           trial   [3];
	logic                     ge      [3];
	logic signed [GSUM_W:0]   qsig    [3];

	// output register
	logic                     m_tvalid_q;
	logic [M_DATA_W-1:0]      m_tdata_q;
	logic                     m_tuser_q;

	assign mul_last  = (step_q == STEP_W'(MUL_STEPS - 1));
	assign div_last  = (step_q == STEP_W'(DIV_STEPS - 1));
	assign cfg_clear = cfg_wen && (cfg_index == CFG_CALIB_MODE || cfg_index == CFG_CALIB_SAMPLES);

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_MUL;
			ST_MUL:  if (mul_last) state_d = ST_FIN;
			ST_FIN: begin
				// advance only once the output register has room
				if (!m_tvalid_q || m_tready) state_d = done ? ST_DIV : ST_IDLE;
			end
			ST_DIV:  if (div_last) state_d = ST_BIAS;
			ST_BIAS: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE: ctrl.s_ready = 1'b1;
			ST_MUL:  ctrl.mul_en  = 1'b1;
			ST_FIN:  ctrl.fin_go  = !m_tvalid_q || m_tready;
			ST_DIV:  ctrl.div_en  = 1'b1;
			ST_BIAS: ctrl.bias_en = 1'b1;
			default: ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			// restart the step count on every state change
			if (state_d != state_q) begin
				step_q <= '0;
			end else if (ctrl.mul_en || ctrl.div_en) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	assign s_tready = ctrl.s_ready;

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_range_q   <= '0;
			gyro_range_q    <= '0;
			calib_mode_q    <= MODE_NORMAL;
			calib_samples_q <= CALIB_SAMPLES_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_ACCEL_RANGE:   accel_range_q   <= cfg_data[1:0];
				CFG_GYRO_RANGE:    gyro_range_q    <= cfg_data[1:0];
				CFG_CALIB_MODE:    calib_mode_q    <= cfg_data[1:0];
				CFG_CALIB_SAMPLES: calib_samples_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- multiplier lanes
	// Shift-add over the raw gyroscope bits, least significant first; the sign bit
	// carries negative weight, so its step subtracts the gain.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (!mlo_q[i][0]) begin
				msum[i] = mhi_q[i];
			end else if (mul_last) begin
				msum[i] = mhi_q[i] - signed'({2'b00, kval_q});
			end else begin
				msum[i] = mhi_q[i] + signed'({2'b00, kval_q});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.s_ready && s_tvalid) begin
			for (int i = 0; i < 3; i++) begin
				raw_a_q[i] <= s_tdata[i*RAW_W +: RAW_W];
				mhi_q[i]   <= '0;
				mlo_q[i]   <= s_tdata[(3+i)*RAW_W +: RAW_W];
			end
			kval_q <= GYRO_K[gyro_range_q];
		end else if (ctrl.mul_en) begin
			for (int i = 0; i < 3; i++) begin
				mhi_q[i] <= {msum[i][HI_W-1], msum[i][HI_W-1:1]};
				mlo_q[i] <= {msum[i][0], mlo_q[i][RAW_W-1:1]};
			end
		end
	end

	// ---------------------------------------------------------------- finishing cycle
	always_comb begin
		logic signed [WIDE_W-1:0] ax;
		logic signed [PROD_W-1:0] prod;
		int                       sh;
		sh     = ASH + int'(accel_range_q);
		cal_on = (calib_mode_q == MODE_GYRO_CAL) || (calib_mode_q == MODE_ACCEL_CAL);
		cnt_n  = cnt_q + CNT_W'(1);
		// a window of zero samples counts as one
		win_n  = (calib_samples_q == '0) ? CNT_W'(1) : calib_samples_q;
		done   = cal_on && (cnt_n >= win_n);
		for (int i = 0; i < 3; i++) begin
			ax = WIDE_W'(raw_a_q[i]);
			// a negative shift means coarser than raw: floor towards minus infinity
			if (sh >= 0) begin
				a_val[i] = sat_a(ax <<< sh);
			end else begin
				a_val[i] = sat_a(ax >>> (-sh));
			end
			prod     = signed'({mhi_q[i], mlo_q[i]});
			g_val[i] = sat_g(WIDE_W'(prod >>> GSH));
			a_out[i] = sat_a(WIDE_W'(a_val[i]) - WIDE_W'(abias_q[i]));
			g_out[i] = sat_g(WIDE_W'(g_val[i]) - WIDE_W'(gbias_q[i]));
			asum_n[i] = asum_q[i] + ASUM_W'(a_val[i]);
			gsum_n[i] = gsum_q[i] + GSUM_W'(g_val[i]);
			div_src[i] = (calib_mode_q == MODE_GYRO_CAL) ? gsum_n[i] : GSUM_W'(asum_n[i]);
		end
	end

	// ---------------------------------------------------------------- sums and biases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				abias_q[i] <= '0;
				gbias_q[i] <= '0;
				asum_q[i]  <= '0;
				gsum_q[i]  <= '0;
			end
			cnt_q <= '0;
		end else begin
			if (cfg_clear) begin
				for (int i = 0; i < 3; i++) begin
					asum_q[i] <= '0;
					gsum_q[i] <= '0;
				end
				cnt_q <= '0;
			end else if (ctrl.fin_go && cal_on) begin
				// close the window on the completing beat, else accumulate
				for (int i = 0; i < 3; i++) begin
					if (done) begin
						asum_q[i] <= '0;
						gsum_q[i] <= '0;
					end else if (calib_mode_q == MODE_GYRO_CAL) begin
						gsum_q[i] <= gsum_n[i];
					end else begin
						asum_q[i] <= asum_n[i];
					end
				end
				cnt_q <= done ? '0 : cnt_n;
			end
			if (ctrl.bias_en) begin
				for (int i = 0; i < 3; i++) begin
					if (dacc_q) begin
						abias_q[i] <= sat_a(WIDE_W'(qsig[i]) - ((i == 2) ? ONE_G : '0));
					end else begin
						gbias_q[i] <= sat_g(WIDE_W'(qsig[i]));
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- divider lanes
	// Restoring division of the magnitude, one quotient bit a cycle; the sign goes
	// back on afterwards, which truncates towards zero.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			trial[i] = {drem_q[i], dq_q[i][GSUM_W-1]};
			ge[i]    = (trial[i] >= {1'b0, ddiv_q});
			qsig[i]  = dneg_q[i] ? -signed'({1'b0, dq_q[i]}) : signed'({1'b0, dq_q[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fin_go && done) begin
			for (int i = 0; i < 3; i++) begin
				dneg_q[i] <= div_src[i][GSUM_W-1];
				dq_q[i]   <= div_src[i][GSUM_W-1] ? GSUM_W'(-div_src[i]) : GSUM_W'(div_src[i]);
				drem_q[i] <= '0;
			end
			ddiv_q <= cnt_n;
			dacc_q <= (calib_mode_q == MODE_ACCEL_CAL);
		end else if (ctrl.div_en) begin
			for (int i = 0; i < 3; i++) begin
				drem_q[i] <= ge[i] ? CNT_W'(trial[i] - {1'b0, ddiv_q}) : trial[i][CNT_W-1:0];
				dq_q[i]   <= {dq_q[i][GSUM_W-2:0], ge[i]};
			end
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.fin_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// outputs use the biases held before any update from this beat
	always_ff @(posedge clk) begin
		if (ctrl.fin_go) begin
			m_tdata_q <= {{PAD_W{1'b0}}, g_out[2], g_out[1], g_out[0],
				a_out[2], a_out[1], a_out[0]};
			m_tuser_q <= done;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

endmodule

>>> src/isbc_checker.sv
// Port-level checker for imu_scale_bias_calibrate, with the bind that attaches it.
// Depends on isbc_pkg and the top level's port list.
module isbc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [isbc_pkg::S_DATA_W-1:0] s_tdata,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [isbc_pkg::M_DATA_W-1:0] m_tdata,
	input logic [0:0]                    m_tuser
);
	import isbc_pkg::*;

	logic [S_DATA_W-1:0] s_seen;
	assign s_seen = s_tdata;

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// the input is still closed when an accepted item has run its multiply steps
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> ##(MUL_STEPS) !s_tready)
		else $error("input reopened before the item finished");

	// a fresh result only appears while the block is busy with its item
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without an item in progress");

	// the completing beat is followed by the bias division, input closed
	a_done_divides: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) && m_tuser[0] |-> !s_tready && s_seen == s_tdata)
		else $error("input open while the new bias is computed");

endmodule

bind imu_scale_bias_calibrate isbc_checker u_isbc_checker (.*);
